/* rtl/utr_pkg.sv */
package utr_pkg;

	// Pose and heading constants
	localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] POS_MIN = -24'sh800000;
	localparam logic signed [30:0] TURN_SCALE = 31'sd683565276;  // 2^32 / (2 pi)
	localparam logic [15:0] TIME_STEP_RESET = 16'd6554;

	// Quarter-wave sine polynomial, Q15
	localparam logic [15:0] SIN_A = 16'd51472;
	localparam logic [15:0] SIN_B = 16'd21024;
	localparam logic [15:0] SIN_C = 16'd2320;

	// One classified command, front to back
	typedef struct packed {
		logic signed [15:0] speed;
		logic [15:0]        dh;
	} cmd_t;

endpackage

/* rtl/utr_front.sv */
module utr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         time_step,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [15:0]  in_speed,
	input  logic signed [15:0]  in_rate,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output utr_pkg::cmd_t       cmd
);
	import utr_pkg::*;

	logic                vld_s1, vld_s2;
	logic signed [15:0]  v_s1, v_s2;
	logic signed [32:0]  wt_s1;
	logic [15:0]         dh_s2;
	logic signed [63:0]  turn_prod;
	logic                en;

	assign en       = !vld_s2 || cmd_ready;
	assign in_ready = en;

	// rate * step * turn scale, rounded to a 16-bit turn fraction
	assign turn_prod = wt_s1 * TURN_SCALE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1  <= in_speed;
			wt_s1 <= in_rate * $signed({1'b0, time_step});
			v_s2  <= v_s1;
			dh_s2 <= turn_prod[59:44] + {15'd0, turn_prod[43]};
		end
	end

	assign cmd_valid = vld_s2;
	assign cmd.speed = v_s2;
	assign cmd.dh    = dh_s2;

endmodule

/* rtl/utr_queue.sv */
module utr_queue #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);
	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   count_q;
	logic         push, pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

/* rtl/utr_trig.sv */
module utr_trig #(
	parameter int ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output logic signed [15:0] sine
);
	import utr_pkg::*;

	localparam logic [31:0] MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

	logic [31:0] p;
	logic [15:0] xr, x;
	logic [15:0] x_s1, x_s2, x_s3, x_s4;
	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [15:0] x2_s2, x2_s3;
	logic [12:0] t1_s3;
	logic [15:0] t2_s4;
	logic [31:0] x2_full;
	logic [27:0] t1_full;
	logic [31:0] t2_full;
	logic [31:0] t3_full;
	logic [15:0] mag;

	// quadrant fold
	assign p  = phase & MASK;
	assign xr = {1'b0, p[29:15]};
	assign x  = p[30] ? (16'd32768 - xr) : xr;

	assign x2_full = x_s1 * x_s1;
	assign t1_full = 28'(SIN_C) * 28'(x2_s2);
	assign t2_full = 32'(SIN_B - {3'd0, t1_s3}) * 32'(x2_s3);
	assign t3_full = 32'(SIN_A - t2_s4) * 32'(x_s4);
	assign mag     = (t3_full[31:15] > 17'd32767) ? 16'd32767 : t3_full[30:15];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x;
			neg_s1 <= p[31];
			x2_s2  <= x2_full[30:15];
			x_s2   <= x_s1;
			neg_s2 <= neg_s1;
			t1_s3  <= t1_full[27:15];
			x2_s3  <= x2_s2;
			x_s3   <= x_s2;
			neg_s3 <= neg_s2;
			t2_s4  <= t2_full[30:15];
			x_s4   <= x_s3;
			neg_s4 <= neg_s3;
			sine   <= neg_s4 ? -$signed(mag) : $signed(mag);
		end
	end

endmodule

/* rtl/utr_back.sv */
module utr_back #(
	parameter int STEPS      = 30,
	parameter int ANGLE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         time_step,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  utr_pkg::cmd_t       cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [23:0]  pos_x,
	output logic signed [23:0]  pos_y,
	output logic [15:0]         heading,
	output logic signed [15:0]  quat_z,
	output logic signed [15:0]  quat_w,
	output logic [5:0]          step_index,
	output logic                last_pose
);
	import utr_pkg::*;

	localparam int NS = 8;
	localparam logic [5:0] LAST_STEP = 6'(STEPS - 1);

	typedef struct packed {
		logic               vld;
		logic               first;
		logic               last;
		logic [5:0]         step;
		logic [15:0]        hd;
		logic signed [15:0] v;
	} tag_t;

	logic               busy_q;
	logic [5:0]         step_q;
	logic [15:0]        hd_q, dh_q;
	logic signed [15:0] v_q;
	logic               en, pop, issue_last;
	logic [15:0]        hd_new;
	tag_t               tag_in;
	tag_t               tag_s [1:NS];

	logic signed [15:0] cos_o, sin_o, sin_h, cos_h;
	logic signed [15:0] qz_s6, qz_s7, qw_s6, qw_s7;
	logic signed [31:0] px_s6, py_s6;
	logic signed [47:0] dx_s7, dy_s7;
	logic signed [48:0] dx_full, dy_full;
	logic signed [47:0] rx, ry;
	logic signed [24:0] sx, sy;
	logic signed [23:0] acc_x_q, acc_y_q;
	logic signed [23:0] base_x, base_y;
	logic signed [15:0] qz_q, qw_q;

	// whole back pipeline advances when the output register can move
	assign en         = !tag_s[NS].vld || out_ready;
	assign issue_last = busy_q && (step_q == LAST_STEP);
	assign pop        = en && cmd_valid && (!busy_q || issue_last);
	assign cmd_ready  = en && (!busy_q || issue_last);
	assign hd_new     = hd_q + dh_q;

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 6'd0;
			hd_q   <= 16'd0;
		end else if (en) begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= 6'd0;
				hd_q   <= 16'd0;
			end else if (busy_q) begin
				busy_q <= !issue_last;
				step_q <= step_q + 6'd1;
				hd_q   <= hd_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			v_q  <= cmd.speed;
			dh_q <= cmd.dh;
		end
	end

	always_comb begin
		tag_in.vld   = busy_q;
		tag_in.first = (step_q == 6'd0);
		tag_in.last  = issue_last;
		tag_in.step  = step_q;
		tag_in.hd    = hd_new;
		tag_in.v     = v_q;
	end

	// step tags follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NS; i++) tag_s[i] <= '0;
		end else if (en) begin
			tag_s[1] <= tag_in;
			for (int i = 2; i <= NS; i++) tag_s[i] <= tag_s[i-1];
		end
	end

	// motion uses old heading, quaternion uses half of new heading
	utr_trig #(.ANGLE_BITS(ANGLE_BITS)) u_cos_o (
		.clk(clk), .en(en), .phase({hd_q + 16'h4000, 16'd0}), .sine(cos_o));
	utr_trig #(.ANGLE_BITS(ANGLE_BITS)) u_sin_o (
		.clk(clk), .en(en), .phase({hd_q, 16'd0}), .sine(sin_o));
	utr_trig #(.ANGLE_BITS(ANGLE_BITS)) u_sin_h (
		.clk(clk), .en(en), .phase({1'b0, hd_new, 15'd0}), .sine(sin_h));
	utr_trig #(.ANGLE_BITS(ANGLE_BITS)) u_cos_h (
		.clk(clk), .en(en), .phase({1'b0, hd_new, 15'd0} + 32'h4000_0000), .sine(cos_h));

	// displacement: v * trig, then * time step, rounded to Q8.16
	assign dx_full = px_s6 * $signed({1'b0, time_step});
	assign dy_full = py_s6 * $signed({1'b0, time_step});
	assign rx      = dx_s7 + 48'sd67108864;
	assign ry      = dy_s7 + 48'sd67108864;
	assign base_x  = tag_s[NS-1].first ? 24'sd0 : acc_x_q;
	assign base_y  = tag_s[NS-1].first ? 24'sd0 : acc_y_q;
	assign sx      = {base_x[23], base_x} + {{4{rx[47]}}, rx[47:27]};
	assign sy      = {base_y[23], base_y} + {{4{ry[47]}}, ry[47:27]};

	always_ff @(posedge clk) begin
		if (en) begin
			px_s6 <= tag_s[5].v * cos_o;
			py_s6 <= tag_s[5].v * sin_o;
			qz_s6 <= sin_h;
			qw_s6 <= cos_h;
			dx_s7 <= dx_full[47:0];
			dy_s7 <= dy_full[47:0];
			qz_s7 <= qz_s6;
			qw_s7 <= qw_s6;
			qz_q  <= qz_s7;
			qw_q  <= qw_s7;
			if (tag_s[NS-1].vld) begin
				acc_x_q <= (sx[24] != sx[23]) ? (sx[24] ? POS_MIN : POS_MAX) : sx[23:0];
				acc_y_q <= (sy[24] != sy[23]) ? (sy[24] ? POS_MIN : POS_MAX) : sy[23:0];
			end
		end
	end

	assign out_valid  = tag_s[NS].vld;
	assign pos_x      = acc_x_q;
	assign pos_y      = acc_y_q;
	assign heading    = tag_s[NS].hd;
	assign quat_z     = qz_q;
	assign quat_w     = qw_q;
	assign step_index = tag_s[NS].step;
	assign last_pose  = tag_s[NS].last;

endmodule

/* rtl/unicycle_trajectory_rollout_core.sv */
// Unicycle trajectory rollout.
// Input stream s_axis: one item per candidate command (speed, yaw rate).
// Output stream m_axis: STEPS pose items per command, tlast on the final one.
// cfg channel writes time_step (unsigned Q0.16 s); cfg_ready is always high,
// write only while the block is idle.
// From command accept to first pose valid a command passes two front
// stages, one queue slot, the step sequencer and an eight-stage pose pipeline.
// The step sequencer in the back part issues one step and one pose per cycle
// while m_axis is not stalled, and takes the next command with the last step.
// The front computes the per-step heading increment and can accept the next
// command while the back still rolls out the current one.
// Reset clears all valids; time_step returns to 0.1 s.
// When m_axis_tready is low the pose pipeline holds, the queue fills, and
// then s_axis_tready drops; no item is lost.
module unicycle_trajectory_rollout_core #(
	parameter int STEPS      = 30,
	parameter int ANGLE_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // linear_velocity[15:0], angular_rate[31:16]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,   // pos_x, pos_y, heading, quat_z, quat_w,
	                                     // step_index, zero pad
	output logic         m_axis_tlast,   // last_pose
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data        // time_step
);
	import utr_pkg::*;

	logic [15:0]        time_step_q;
	logic               fc_valid, fc_ready, bc_valid, bc_ready;
	cmd_t               fc_cmd, bc_cmd;
	logic signed [23:0] pos_x, pos_y;
	logic [15:0]        heading;
	logic signed [15:0] quat_z, quat_w;
	logic [5:0]         step_index;

	assign cfg_ready = 1'b1;

	// time step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) time_step_q <= TIME_STEP_RESET;
		else if (cfg_valid) time_step_q <= cfg_data;
	end

	utr_front u_front (
		.clk(clk), .arst_n(arst_n), .time_step(time_step_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_speed(s_axis_tdata[15:0]), .in_rate(s_axis_tdata[31:16]),
		.cmd_valid(fc_valid), .cmd_ready(fc_ready), .cmd(fc_cmd));

	utr_queue #(.W($bits(cmd_t))) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fc_valid), .wr_ready(fc_ready), .wr_data(fc_cmd),
		.rd_valid(bc_valid), .rd_ready(bc_ready), .rd_data(bc_cmd));

	utr_back #(.STEPS(STEPS), .ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .time_step(time_step_q),
		.cmd_valid(bc_valid), .cmd_ready(bc_ready), .cmd(bc_cmd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading),
		.quat_z(quat_z), .quat_w(quat_w), .step_index(step_index),
		.last_pose(m_axis_tlast));

	assign m_axis_tdata = {2'b00, step_index, quat_w, quat_z, heading, pos_y, pos_x};

endmodule

/* sim/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = 30;
	localparam int ANGLE_BITS = 16;
	localparam int NUM_RANDOM = 260;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic signed [15:0] rate;
		logic signed [15:0] speed;
	} cmd_item_t;

	typedef struct packed {
		logic [23:0] x;
		logic [23:0] y;
		logic [15:0] hdg;
		logic [15:0] qz;
		logic [15:0] qw;
		logic [5:0]  idx;
		logic        last;
	} pose_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [103:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] cfg_data;

	unicycle_trajectory_rollout_core #(.STEPS(STEPS), .ANGLE_BITS(ANGLE_BITS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	cmd_item_t cmd_queue[$];
	pose_t     pose_expect[$];
	logic [15:0] step_len;
	int  mismatches;
	bit  stim_done;
	bit  sender_paused;
	int  hold_cycles;
	longint cycle_count;
	int  offered_count = 0;
	int  taken_count = 0;

	// Append one command to the pending list
	function automatic void queue_cmd(cmd_item_t c);
		cmd_queue = {cmd_queue, c};
	endfunction

	// Polynomial sine on a 32-bit turn phase
	function automatic logic signed [15:0] turn_sine(logic [31:0] phase);
		logic [31:0] p;
		logic [1:0] quad;
		logic [63:0] x, x2, t;
		p = phase & ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
		quad = p[31:30];
		x = {49'd0, p[29:15]};
		if (quad[0])
			x = 64'd32768 - x;
		x2 = (x * x) >> 15;
		t = (64'd2320 * x2) >> 15;
		t = 64'd21024 - t;
		t = (t * x2) >> 15;
		t = 64'd51472 - t;
		t = (t * x) >> 15;
		if (t > 64'd32767)
			t = 64'd32767;
		return quad[1] ? -$signed(t[15:0]) : $signed(t[15:0]);
	endfunction

	function automatic logic signed [15:0] turn_cosine(logic [31:0] phase);
		return turn_sine(phase + 32'h4000_0000);
	endfunction

	function automatic logic signed [23:0] clamp_pos(longint v);
		if (v > 64'sd8388607)
			return 24'sh7FFFFF;
		if (v < -64'sd8388608)
			return 24'sh800000;
		return v[23:0];
	endfunction

	// Roll out one command from the origin, queue every pose
	task automatic rollout_poses(cmd_item_t c);
		longint v, w, dh, dx, dy, px, py;
		logic [15:0] hdg;
		pose_t p;
		v = c.speed;
		w = c.rate;
		px = 0;
		py = 0;
		hdg = '0;
		dh = (w * longint'(step_len) * 64'sd683565276 + (64'sd1 <<< 43)) >>> 44;
		for (int k = 0; k < STEPS; k++) begin
			dx = v * longint'(turn_cosine({hdg, 16'd0})) * longint'(step_len);
			dy = v * longint'(turn_sine({hdg, 16'd0})) * longint'(step_len);
			px = clamp_pos(px + ((dx + (64'sd1 <<< 26)) >>> 27));
			py = clamp_pos(py + ((dy + (64'sd1 <<< 26)) >>> 27));
			hdg = hdg + dh[15:0];
			p.x = px[23:0];
			p.y = py[23:0];
			p.hdg = hdg;
			p.qz = turn_sine({1'b0, hdg, 15'd0});
			p.qw = turn_cosine({1'b0, hdg, 15'd0});
			p.idx = k[5:0];
			p.last = (k == STEPS - 1);
			pose_expect = {pose_expect, p};
		end
	endtask

	// Driver: one command per item, random gap after each
	int send_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_gap <= 0;
		end else if (s_axis_tvalid && taken_count != offered_count) begin
			// hold offered item until it is taken
		end else if (send_gap > 0) begin
			s_axis_tvalid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (cmd_queue.size() > 0 && !sender_paused) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= cmd_queue[0];
			offered_count <= offered_count + 1;
			send_gap <= $urandom_range(0, 13);
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Predict at acceptance
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			taken_count <= taken_count + 1;
			rollout_poses(cmd_queue.pop_front());
		end
	end

	// Receiver ready with random stalls and one long hold-off
	int ready_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_gap <= 0;
		end else if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (ready_gap > 0) begin
			m_axis_tready <= 1'b0;
			ready_gap <= ready_gap - 1;
		end else if (m_axis_tready && m_axis_tvalid) begin
			ready_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: compare each pose against the oldest expectation
	always @(posedge clk) begin
		pose_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[101:0], m_axis_tlast};
			got.x = m_axis_tdata[23:0];
			got.y = m_axis_tdata[47:24];
			got.hdg = m_axis_tdata[63:48];
			got.qz = m_axis_tdata[79:64];
			got.qw = m_axis_tdata[95:80];
			got.idx = m_axis_tdata[101:96];
			got.last = m_axis_tlast;
			if (pose_expect.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pose %h", got);
			end else begin
				want = pose_expect.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pose mismatch: exp x=%h y=%h h=%h z=%h w=%h i=%0d l=%b | got x=%h y=%h h=%h z=%h w=%h i=%0d l=%b",
							want.x, want.y, want.hdg, want.qz, want.qw, want.idx, want.last,
							got.x, got.y, got.hdg, got.qz, got.qw, got.idx, got.last);
				end
			end
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic wait_drained();
		while (cmd_queue.size() > 0 || pose_expect.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_step(logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		step_len = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic cmd_item_t rand_cmd();
		cmd_item_t c;
		c.speed = 16'($urandom);
		c.rate = 16'($urandom);
		// mostly realistic speeds and rates
		if ($urandom_range(0, 3) != 0) begin
			c.speed = $signed(16'($urandom_range(0, 16384))) - 16'sd4096;
			c.rate = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
		end
		return c;
	endfunction

	initial begin
		logic [15:0] step_set[4];
		cmd_item_t c;
		mismatches = 0;
		stim_done = 0;
		sender_paused = 0;
		hold_cycles = 0;
		cycle_count = 0;
		step_len = 16'd6554;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, zero command, default step
		queue_cmd('{rate: 16'sd0, speed: 16'sd0});
		queue_cmd('{rate: 16'sd0, speed: 16'sd4096});
		queue_cmd('{rate: 16'sd4096, speed: 16'sd4096});
		queue_cmd('{rate: -16'sd1638, speed: 16'sd12288});
		queue_cmd('{rate: 16'sh7FFF, speed: 16'sh7FFF});
		queue_cmd('{rate: 16'sh8000, speed: 16'sh8000});
		queue_cmd('{rate: 16'sh8000, speed: 16'sh7FFF});
		queue_cmd('{rate: 16'sh7FFF, speed: 16'sh8000});
		queue_cmd('{rate: -16'sd4096, speed: -16'sd4096});
		queue_cmd('{rate: 16'shFFFF, speed: 16'shFFFF});
		wait_drained();

		// Saturation: largest step with full speed
		write_step(16'hFFFF);
		queue_cmd('{rate: 16'sd0, speed: 16'sh7FFF});
		queue_cmd('{rate: 16'sh7FFF, speed: 16'sh8000});
		queue_cmd('{rate: 16'sd100, speed: 16'sh8000});
		wait_drained();
		// Zero step: no motion
		write_step(16'd0);
		queue_cmd('{rate: 16'sh7FFF, speed: 16'sh7FFF});
		queue_cmd('{rate: 16'sh5555, speed: 16'shAAAA});
		wait_drained();
		write_step(16'd1);
		queue_cmd('{rate: 16'sh7FFF, speed: 16'sh7FFF});
		wait_drained();

		// Random phases across several step sizes
		step_set[0] = 16'd6554;
		step_set[1] = 16'hFFFF;
		step_set[2] = 16'd1;
		step_set[3] = 16'd0;
		for (int ph = 0; ph < 5; ph++) begin
			write_step(ph < 4 ? step_set[ph] : 16'($urandom));
			for (int i = 0; i < NUM_RANDOM / 5; i++)
				queue_cmd(rand_cmd());
			if (ph == 1) begin
				// long output hold-off while input keeps coming
				hold_cycles = 400;
			end
			if (ph == 2) begin
				// sender pause until all poses are out
				while (cmd_queue.size() > NUM_RANDOM / 10)
					@(posedge clk);
				sender_paused = 1;
				while (pose_expect.size() > 0 || s_axis_tvalid)
					@(posedge clk);
				sender_paused = 0;
			end
			wait_drained();
		end
		write_step(16'd6554);
		queue_cmd(rand_cmd());
		wait_drained();

		if (mismatches == 0 && pose_expect.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
